@@ sv/cdic_pkg.sv @@
`default_nettype none

package cdic_pkg;

    // Field widths
    localparam int MODE_W     = 1;
    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;
    localparam int YEAR_W     = 14;
    localparam int IDX_W      = 22;
    localparam int YDAY_W     = 9;
    localparam int WDAY_W     = 3;
    localparam int CLIM_W     = 7;
    localparam int BIAS_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 64;

    // Internal widths
    localparam int EIDX_W     = 23;   // index after adding the 1900 offset
    localparam int CENT_W     = 8;    // year / 100
    localparam int REM_W      = 7;    // year % 100
    localparam int MOFF_W     = 10;   // signed month offset
    localparam int DIFF_W     = 24;   // signed index differences
    localparam int RECIP_W    = 24;
    localparam int PROD_W     = EIDX_W + RECIP_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTURY_LIMIT = 2'd0,
        CFG_OFFSET_1900   = 2'd1,
        CFG_WEEKDAY_BIAS  = 2'd2
    } cfg_index_t;

    localparam logic [CLIM_W-1:0] CLIM_RST   = 7'd50;
    localparam logic [IDX_W-1:0]  OFFSET_RST = 22'd693608;
    localparam logic [BIAS_W-1:0] BIAS_RST   = 3'd1;

    localparam logic [YEAR_W-1:0] CUTOVER_YEAR      = 14'd1752;
    localparam logic [YEAR_W-1:0] CENT_START        = 14'd1700;
    localparam logic [YEAR_W-1:0] QUAD_START        = 14'd1600;
    localparam logic [CENT_W-1:0] CENT_BASE         = 8'd17;
    localparam logic [CENT_W-3:0] QUAD_BASE         = 6'd4;
    localparam logic [IDX_W-1:0]  SMALL_INDEX_LIMIT = 22'h00FFFF;
    localparam logic [YDAY_W-1:0] DAYS_YEAR         = 9'd365;

    // Year estimate: floor((idx - EST_BIAS) * RECIP_YEAR / 2^32), within one year
    localparam logic [EIDX_W-1:0]  EST_BIAS         = 23'd7;
    localparam logic [RECIP_W-1:0] RECIP_YEAR       = 24'd11759221;
    localparam int                 RECIP_YEAR_SHIFT = 32;

    // y / 100 == (y * 5243) >> 19, exact for 14-bit y
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;

    function automatic logic [CENT_W-1:0] div100(input logic [YEAR_W-1:0] y);
        logic [26:0] p;
        p = 27'(y) * 27'(RECIP_100);
        return p[RECIP_100_SHIFT +: CENT_W];
    endfunction

    function automatic logic [REM_W-1:0] rem100(input logic [YEAR_W-1:0] y,
                                                input logic [CENT_W-1:0] q);
        logic [YEAR_W-1:0] t;
        t = y - 14'(q) * 14'd100;
        return t[REM_W-1:0];
    endfunction

    // Julian rule through the cutover year, Gregorian after it
    function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                     input logic [CENT_W-1:0] q,
                                     input logic [REM_W-1:0]  r);
        return (y[1:0] == 2'd0) &&
               ((y <= CUTOVER_YEAR) || (r != 7'd0) || (q[1:0] == 2'd0));
    endfunction

    // Leap flag of year y + k, from the quotient and remainder of y
    function automatic logic leap_ahead(input logic [YEAR_W-1:0] y,
                                        input logic [CENT_W-1:0] q,
                                        input logic [REM_W-1:0]  r,
                                        input logic [1:0]        k);
        logic [YEAR_W-1:0] yk;
        logic [CENT_W-1:0] rk;
        logic [CENT_W-1:0] qk;
        yk = y + 14'(k);
        rk = {1'b0, r} + 8'(k);
        qk = q;
        if (rk >= 8'd100) begin
            rk = rk - 8'd100;
            qk = q + 8'd1;
        end
        return is_leap(yk, qk, rk[REM_W-1:0]);
    endfunction

    // Index of the last day of year y
    function automatic logic [EIDX_W-1:0] year_end(input logic [YEAR_W-1:0] y,
                                                   input logic [EIDX_W-1:0] y365,
                                                   input logic [CENT_W-1:0] q);
        logic [CENT_W-1:0] cent;
        logic [CENT_W-3:0] quad;
        cent = (y > CENT_START) ? q - CENT_BASE : '0;
        quad = (y > QUAD_START) ? q[CENT_W-1:2] - QUAD_BASE : '0;
        return y365 + 23'(y[YEAR_W-1:2]) - 23'(cent) + 23'(quad);
    endfunction

    // Days before the first of month m, no leap day; two's complement
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MON_W-1:0] m);
        logic [MOFF_W-1:0] o;
        case (m)
            4'd0:    o = 10'h3E1;    // minus 31
            4'd1:    o = 10'd0;
            4'd2:    o = 10'd31;
            4'd3:    o = 10'd59;
            4'd4:    o = 10'd90;
            4'd5:    o = 10'd120;
            4'd6:    o = 10'd151;
            4'd7:    o = 10'd181;
            4'd8:    o = 10'd212;
            4'd9:    o = 10'd243;
            4'd10:   o = 10'd273;
            4'd11:   o = 10'd304;
            4'd12:   o = 10'd334;
            4'd13:   o = 10'd365;
            4'd14:   o = 10'd396;
            default: o = 10'd426;
        endcase
        return o;
    endfunction

    // First non-leap day of year in month m, for months 3 to 12
    function automatic logic [YDAY_W-1:0] month_start(input logic [MON_W-1:0] m);
        logic [YDAY_W-1:0] s;
        case (m)
            4'd3:    s = 9'd60;
            4'd4:    s = 9'd91;
            4'd5:    s = 9'd121;
            4'd6:    s = 9'd152;
            4'd7:    s = 9'd182;
            4'd8:    s = 9'd213;
            4'd9:    s = 9'd244;
            4'd10:   s = 9'd274;
            4'd11:   s = 9'd305;
            4'd12:   s = 9'd335;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ sv/calendar_date_day_index_converter_top.sv @@
// Throughput: one item per cycle while the output register is empty or m_tready
// is high; six register stages with a valid bit each, held together
// by one stall enable taken from the output register.
// The year search is unrolled: one estimate multiply, one year-end evaluation
// and a three-way pick of the year around it.
// Reset (aresetn low at a clock edge) clears all valid bits and loads the
// register defaults: century_limit 50, offset_1900 693608, weekday_bias 1.
`default_nettype none

module calendar_date_day_index_converter_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [cdic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cdic_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // tdata: day_in[4:0], month_in[8:5], year_in[22:9], index_in[44:23], zero fill
    input  wire logic [cdic_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: mode[0]
    input  wire logic [cdic_pkg::MODE_W-1:0]      s_tuser,
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // tdata: index_out[21:0], year_out[35:22], month_out[39:36], day_out[44:40],
    //        yday_out[53:45], wday_out[56:54], zero fill
    output logic [cdic_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int NSTAGE = 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [cdic_pkg::CLIM_W-1:0] climit_reg, climit_next;
    logic [cdic_pkg::IDX_W-1:0]  offset_reg, offset_next;
    logic [cdic_pkg::BIAS_W-1:0] bias_reg,   bias_next;

    always_comb begin
        climit_next = climit_reg;
        offset_next = offset_reg;
        bias_next   = bias_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                cdic_pkg::CFG_CENTURY_LIMIT: climit_next = cfg_wdata[cdic_pkg::CLIM_W-1:0];
                cdic_pkg::CFG_OFFSET_1900:   offset_next = cfg_wdata[cdic_pkg::IDX_W-1:0];
                cdic_pkg::CFG_WEEKDAY_BIAS:  bias_next   = cfg_wdata[cdic_pkg::BIAS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            climit_reg <= cdic_pkg::CLIM_RST;
            offset_reg <= cdic_pkg::OFFSET_RST;
            bias_reg   <= cdic_pkg::BIAS_RST;
        end else begin
            climit_reg <= climit_next;
            offset_reg <= offset_next;
            bias_reg   <= bias_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic [NSTAGE-1:0] vld_reg, vld_next;
    logic [NSTAGE-1:0] mode_reg, mode_next;
    logic              adv;

    assign adv      = !vld_reg[NSTAGE-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTAGE-1];

    assign vld_next  = {vld_reg[NSTAGE-2:0], s_tvalid};
    assign mode_next = {mode_reg[NSTAGE-2:0], s_tuser[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode_reg <= mode_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offset small indices, window the year
    // ------------------------------------------------------------------
    logic [cdic_pkg::DAY_W-1:0]  day_in;
    logic [cdic_pkg::MON_W-1:0]  month_in;
    logic [cdic_pkg::YEAR_W-1:0] year_in;
    logic [cdic_pkg::IDX_W-1:0]  index_in;

    assign day_in   = s_tdata[4:0];
    assign month_in = s_tdata[8:5];
    assign year_in  = s_tdata[22:9];
    assign index_in = s_tdata[44:23];

    logic [cdic_pkg::EIDX_W-1:0] idx_s1_reg, idx_s1_next;
    logic                        zero_s1_reg, zero_s1_next;
    logic [cdic_pkg::YEAR_W-1:0] yd_s1_reg, yd_s1_next;     // year before the date's year
    logic [cdic_pkg::YEAR_W-1:0] yr_s1_reg, yr_s1_next;     // the date's full year
    logic [cdic_pkg::DAY_W-1:0]  d_s1_reg, d_s1_next;
    logic [cdic_pkg::MON_W-1:0]  m_s1_reg, m_s1_next;

    always_comb begin
        zero_s1_next = (index_in == '0);
        if (index_in <= cdic_pkg::SMALL_INDEX_LIMIT) begin
            idx_s1_next = 23'(index_in) + 23'(offset_reg);
        end else begin
            idx_s1_next = 23'(index_in);
        end
        if (zero_s1_next) begin
            idx_s1_next = '0;
        end

        if (year_in < 14'(climit_reg)) begin
            yr_s1_next = year_in + 14'd2000;
            yd_s1_next = year_in + 14'd1999;
        end else if (year_in < 14'd100) begin
            yr_s1_next = year_in + 14'd1900;
            yd_s1_next = year_in + 14'd1899;
        end else begin
            yr_s1_next = year_in;
            yd_s1_next = year_in - 14'd1;
        end
        d_s1_next = day_in;
        m_s1_next = month_in;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_s1_reg  <= idx_s1_next;
            zero_s1_reg <= zero_s1_next;
            yd_s1_reg   <= yd_s1_next;
            yr_s1_reg   <= yr_s1_next;
            d_s1_reg    <= d_s1_next;
            m_s1_reg    <= m_s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: year estimate, weekday, century split of the year before the date's year
    // ------------------------------------------------------------------
    logic [cdic_pkg::YEAR_W-1:0] e_s2_reg, e_s2_next;
    logic [cdic_pkg::EIDX_W-1:0] idx_s2_reg, idx_s2_next;
    logic                        zero_s2_reg, zero_s2_next;
    logic [cdic_pkg::WDAY_W-1:0] wd_s2_reg, wd_s2_next;
    logic [cdic_pkg::YEAR_W-1:0] yd_s2_reg, yd_s2_next;
    logic [cdic_pkg::CENT_W-1:0] qd_s2_reg, qd_s2_next;
    logic [cdic_pkg::EIDX_W-1:0] yd365_s2_reg, yd365_s2_next;
    logic [cdic_pkg::DAY_W-1:0]  d_s2_reg, d_s2_next;
    logic [cdic_pkg::MON_W-1:0]  m_s2_reg, m_s2_next;

    logic [cdic_pkg::EIDX_W-1:0] est_a;
    logic [cdic_pkg::PROD_W-1:0] est_p;
    logic [cdic_pkg::DIFF_W-1:0] wd_sum;
    logic [5:0]                  wd_fold;
    logic [3:0]                  wd_fold2;

    always_comb begin
        est_a = (idx_s1_reg >= cdic_pkg::EST_BIAS) ? idx_s1_reg - cdic_pkg::EST_BIAS : '0;
        est_p = cdic_pkg::PROD_W'(est_a) * cdic_pkg::PROD_W'(cdic_pkg::RECIP_YEAR);
        e_s2_next = est_p[cdic_pkg::RECIP_YEAR_SHIFT +: cdic_pkg::YEAR_W];

        // 8 == 1 mod 7: add the octal digits, then fold once more
        wd_sum  = 24'(idx_s1_reg) + 24'(bias_reg);
        wd_fold = '0;
        for (int i = 0; i < cdic_pkg::DIFF_W / 3; i++) begin
            wd_fold = wd_fold + 6'(wd_sum[3*i +: 3]);
        end
        wd_fold2 = 4'(wd_fold[5:3]) + 4'(wd_fold[2:0]);
        if (wd_fold2 >= 4'd14) begin
            wd_fold2 = wd_fold2 - 4'd14;
        end else if (wd_fold2 >= 4'd7) begin
            wd_fold2 = wd_fold2 - 4'd7;
        end
        wd_s2_next = wd_fold2[cdic_pkg::WDAY_W-1:0];

        idx_s2_next  = idx_s1_reg;
        zero_s2_next = zero_s1_reg;

        yd_s2_next    = yd_s1_reg;
        qd_s2_next    = cdic_pkg::div100(yd_s1_reg);
        yd365_s2_next = 23'(yd_s1_reg) * 23'(cdic_pkg::DAYS_YEAR);
        d_s2_next     = d_s1_reg;
        m_s2_next     = m_s1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_s2_reg     <= e_s2_next;
            idx_s2_reg   <= idx_s2_next;
            zero_s2_reg  <= zero_s2_next;
            wd_s2_reg    <= wd_s2_next;
            yd_s2_reg    <= yd_s2_next;
            qd_s2_reg    <= qd_s2_next;
            yd365_s2_reg <= yd365_s2_next;
            d_s2_reg     <= d_s2_next;
            m_s2_reg     <= m_s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: century split of the estimate; year end before the date
    // ------------------------------------------------------------------
    logic [cdic_pkg::YEAR_W-1:0] e_s3_reg, e_s3_next;
    logic [cdic_pkg::CENT_W-1:0] q_s3_reg, q_s3_next;
    logic [cdic_pkg::EIDX_W-1:0] e365_s3_reg, e365_s3_next;
    logic [cdic_pkg::EIDX_W-1:0] idx_s3_reg, idx_s3_next;
    logic                        zero_s3_reg, zero_s3_next;
    logic [cdic_pkg::WDAY_W-1:0] wd_s3_reg, wd_s3_next;
    logic [cdic_pkg::EIDX_W-1:0] fd_s3_reg, fd_s3_next;
    logic                        lp_s3_reg, lp_s3_next;
    logic [cdic_pkg::DAY_W-1:0]  d_s3_reg, d_s3_next;
    logic [cdic_pkg::MON_W-1:0]  m_s3_reg, m_s3_next;

    logic [cdic_pkg::REM_W-1:0]  rd_s3;

    always_comb begin
        e_s3_next    = e_s2_reg;
        q_s3_next    = cdic_pkg::div100(e_s2_reg);
        e365_s3_next = 23'(e_s2_reg) * 23'(cdic_pkg::DAYS_YEAR);
        idx_s3_next  = idx_s2_reg;
        zero_s3_next = zero_s2_reg;
        wd_s3_next   = wd_s2_reg;

        rd_s3      = cdic_pkg::rem100(yd_s2_reg, qd_s2_reg);
        fd_s3_next = cdic_pkg::year_end(yd_s2_reg, yd365_s2_reg, qd_s2_reg);
        lp_s3_next = cdic_pkg::leap_ahead(yd_s2_reg, qd_s2_reg, rd_s3, 2'd1);
        d_s3_next  = d_s2_reg;
        m_s3_next  = m_s2_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_s3_reg    <= e_s3_next;
            q_s3_reg    <= q_s3_next;
            e365_s3_reg <= e365_s3_next;
            idx_s3_reg  <= idx_s3_next;
            zero_s3_reg <= zero_s3_next;
            wd_s3_reg   <= wd_s3_next;
            fd_s3_reg   <= fd_s3_next;
            lp_s3_reg   <= lp_s3_next;
            d_s3_reg    <= d_s3_next;
            m_s3_reg    <= m_s3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: year end of the estimate and leap flags around it;
    //          final day index of the date
    // ------------------------------------------------------------------
    logic [cdic_pkg::YEAR_W-1:0] e_s4_reg, e_s4_next;
    logic [cdic_pkg::EIDX_W-1:0] fe_s4_reg, fe_s4_next;
    logic [2:0]                  lp_s4_reg, lp_s4_next;   // leap of e, e+1, e+2
    logic [cdic_pkg::EIDX_W-1:0] idx_s4_reg, idx_s4_next;
    logic                        zero_s4_reg, zero_s4_next;
    logic [cdic_pkg::WDAY_W-1:0] wd_s4_reg, wd_s4_next;
    logic [cdic_pkg::IDX_W-1:0]  ix_s4_reg, ix_s4_next;

    logic [cdic_pkg::REM_W-1:0]  re_s4;
    logic [cdic_pkg::MOFF_W-1:0] moff_s4;
    logic [cdic_pkg::DIFF_W-1:0] ix_sum;

    always_comb begin
        re_s4         = cdic_pkg::rem100(e_s3_reg, q_s3_reg);
        fe_s4_next    = cdic_pkg::year_end(e_s3_reg, e365_s3_reg, q_s3_reg);
        lp_s4_next[0] = cdic_pkg::leap_ahead(e_s3_reg, q_s3_reg, re_s4, 2'd0);
        lp_s4_next[1] = cdic_pkg::leap_ahead(e_s3_reg, q_s3_reg, re_s4, 2'd1);
        lp_s4_next[2] = cdic_pkg::leap_ahead(e_s3_reg, q_s3_reg, re_s4, 2'd2);
        e_s4_next     = e_s3_reg;
        idx_s4_next   = idx_s3_reg;
        zero_s4_next  = zero_s3_reg;
        wd_s4_next    = wd_s3_reg;

        // wraps modulo 2^22; month 0 gives a negative offset
        moff_s4 = cdic_pkg::month_offset(m_s3_reg);
        ix_sum  = 24'(fd_s3_reg) + 24'(d_s3_reg)
                + {{(cdic_pkg::DIFF_W - cdic_pkg::MOFF_W){moff_s4[cdic_pkg::MOFF_W-1]}}, moff_s4}
                + 24'((m_s3_reg >= 4'd3) && lp_s3_reg);
        ix_s4_next = ix_sum[cdic_pkg::IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_s4_reg    <= e_s4_next;
            fe_s4_reg   <= fe_s4_next;
            lp_s4_reg   <= lp_s4_next;
            idx_s4_reg  <= idx_s4_next;
            zero_s4_reg <= zero_s4_next;
            wd_s4_reg   <= wd_s4_next;
            ix_s4_reg   <= ix_s4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: pick the year from e, e+1, e+2 and the day of year
    // ------------------------------------------------------------------
    logic [cdic_pkg::YEAR_W-1:0] y_s5_reg, y_s5_next;
    logic [cdic_pkg::YDAY_W-1:0] n_s5_reg, n_s5_next;
    logic                        lp_s5_reg, lp_s5_next;
    logic                        zero_s5_reg, zero_s5_next;
    logic [cdic_pkg::WDAY_W-1:0] wd_s5_reg, wd_s5_next;
    logic [cdic_pkg::IDX_W-1:0]  ix_s5_reg, ix_s5_next;

    logic [cdic_pkg::DIFF_W-1:0] dd_s5;
    logic [cdic_pkg::DIFF_W-1:0] dsel_s5;
    logic [cdic_pkg::YDAY_W-1:0] len0_s5;
    logic [cdic_pkg::YDAY_W-1:0] len1_s5;

    always_comb begin
        dd_s5   = {1'b0, idx_s4_reg} - {1'b0, fe_s4_reg};
        len0_s5 = cdic_pkg::DAYS_YEAR + 9'(lp_s4_reg[0]);
        len1_s5 = cdic_pkg::DAYS_YEAR + 9'(lp_s4_reg[1]);
        if (dd_s5[cdic_pkg::DIFF_W-1] || (dd_s5 == '0)) begin
            // estimate one year high
            dsel_s5    = dd_s5 + 24'(len0_s5);
            y_s5_next  = e_s4_reg;
            lp_s5_next = lp_s4_reg[0];
        end else if (dd_s5 <= 24'(len1_s5)) begin
            dsel_s5    = dd_s5;
            y_s5_next  = e_s4_reg + 14'd1;
            lp_s5_next = lp_s4_reg[1];
        end else begin
            // estimate one year low
            dsel_s5    = dd_s5 - 24'(len1_s5);
            y_s5_next  = e_s4_reg + 14'd2;
            lp_s5_next = lp_s4_reg[2];
        end
        n_s5_next    = dsel_s5[cdic_pkg::YDAY_W-1:0];
        zero_s5_next = zero_s4_reg;
        wd_s5_next   = wd_s4_reg;
        ix_s5_next   = ix_s4_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_s5_reg    <= y_s5_next;
            n_s5_reg    <= n_s5_next;
            lp_s5_reg   <= lp_s5_next;
            zero_s5_reg <= zero_s5_next;
            wd_s5_reg   <= wd_s5_next;
            ix_s5_reg   <= ix_s5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: month and day, output register
    // ------------------------------------------------------------------
    logic [cdic_pkg::IDX_W-1:0]  index_out_reg, index_out_next;
    logic [cdic_pkg::YEAR_W-1:0] year_out_reg,  year_out_next;
    logic [cdic_pkg::MON_W-1:0]  month_out_reg, month_out_next;
    logic [cdic_pkg::DAY_W-1:0]  day_out_reg,   day_out_next;
    logic [cdic_pkg::YDAY_W-1:0] yday_out_reg,  yday_out_next;
    logic [cdic_pkg::WDAY_W-1:0] wday_out_reg,  wday_out_next;

    logic                        jan_feb;
    logic [cdic_pkg::YDAY_W-1:0] np_s6;
    logic [cdic_pkg::YDAY_W-1:0] dy_s6;
    logic [cdic_pkg::MON_W-1:0]  mth_s6;

    always_comb begin
        jan_feb = (n_s5_reg <= 9'd59) || (lp_s5_reg && (n_s5_reg == 9'd60));
        np_s6   = n_s5_reg - 9'(lp_s5_reg);
        mth_s6  = 4'd3;
        for (int k = 4; k <= 12; k++) begin
            if (np_s6 >= cdic_pkg::month_start(4'(k))) begin
                mth_s6 = 4'(k);
            end
        end
        dy_s6 = np_s6 - cdic_pkg::month_start(mth_s6) + 9'd1;
        if (jan_feb) begin
            if (n_s5_reg >= 9'd32) begin
                mth_s6 = 4'd2;
                dy_s6  = n_s5_reg - 9'd31;
            end else begin
                mth_s6 = 4'd1;
                dy_s6  = n_s5_reg;
            end
        end

        index_out_next = '0;
        year_out_next  = '0;
        month_out_next = '0;
        day_out_next   = '0;
        yday_out_next  = '0;
        wday_out_next  = '0;
        if (!mode_reg[NSTAGE-2]) begin
            index_out_next = ix_s5_reg;
        end else if (!zero_s5_reg) begin
            year_out_next  = y_s5_reg;
            month_out_next = mth_s6;
            day_out_next   = dy_s6[cdic_pkg::DAY_W-1:0];
            yday_out_next  = n_s5_reg;
            wday_out_next  = wd_s5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            index_out_reg <= index_out_next;
            year_out_reg  <= year_out_next;
            month_out_reg <= month_out_next;
            day_out_reg   <= day_out_next;
            yday_out_reg  <= yday_out_next;
            wday_out_reg  <= wday_out_next;
        end
    end

    assign m_tdata = {7'd0, wday_out_reg, yday_out_reg, day_out_reg,
                      month_out_reg, year_out_reg, index_out_reg};

`ifndef SYNTHESIS
    a_yday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[4] && mode_reg[4] && !zero_s5_reg |->
            (n_s5_reg >= 9'd1) && (n_s5_reg <= 9'd366))
        else $error("day of year out of range after year pick");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mode_reg[NSTAGE-1] && (yday_out_reg != '0) |->
            (month_out_reg >= 4'd1) && (month_out_reg <= 4'd12) &&
            (day_out_reg >= 5'd1) && (day_out_reg <= 5'd31))
        else $error("month or day out of range");

    a_mode0_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !mode_reg[NSTAGE-1] |->
            (year_out_reg == '0) && (month_out_reg == '0) && (day_out_reg == '0) &&
            (yday_out_reg == '0) && (wday_out_reg == '0))
        else $error("date fields set on a date to index result");
`endif

endmodule

`default_nettype wire

@@ test/tb_calendar_date_day_index_converter_top.sv @@
`timescale 1ns / 100ps

module tb_calendar_date_day_index_converter_top;

    import cdic_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [YDAY_W-1:0] yday;
        logic [WDAY_W-1:0] wday;
    } calendar_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_index_t            cfg_index = CFG_CENTURY_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // tdata: day_in, month_in, year_in, index_in, zero fill
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    // tuser: mode
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // tdata: index_out, year_out, month_out, day_out, yday_out, wday_out, zero fill
    logic [M_TDATA_W-1:0]  m_tdata;

    // Conversion settings as the block should hold them
    logic [CLIM_W-1:0] year_window_limit  = CLIM_RST;
    logic [IDX_W-1:0]  small_index_offset = OFFSET_RST;
    logic [BIAS_W-1:0] weekday_shift      = BIAS_RST;

    calendar_result_t pending_conversions[$];
    int error_count   = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_left     = 0;

    calendar_date_day_index_converter_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Julian rule through the cutover year, Gregorian after
    function automatic bit leap_year(input longint y);
        if (y <= longint'(CUTOVER_YEAR))
            return (y % 4) == 0;
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic longint last_day_index(input longint y);
        longint cent;
        longint quad;
        cent = (y > 1700) ? y / 100 - 17 : 0;
        quad = (y > 1600) ? (y - 1600) / 400 : 0;
        return y * 365 + y / 4 - cent + quad;
    endfunction

    function automatic logic [IDX_W-1:0] date_index(input logic [DAY_W-1:0] d,
                                                    input logic [MON_W-1:0] m,
                                                    input logic [YEAR_W-1:0] y_in);
        longint y;
        longint doy;
        y = longint'(y_in);
        if (y < longint'(year_window_limit))
            y += 2000;
        if (y < 100)
            y += 1900;
        if (m <= 2)
            doy = longint'(d) + 31 * (longint'(m) - 1);
        else
            doy = longint'(d) + (leap_year(y) ? 1 : 0) + (306 * longint'(m) - 323) / 10;
        return IDX_W'(last_day_index(y - 1) + doy);
    endfunction

    function automatic calendar_result_t predict_conversion(input bit mode,
                                                            input logic [DAY_W-1:0] d,
                                                            input logic [MON_W-1:0] m,
                                                            input logic [YEAR_W-1:0] y,
                                                            input logic [IDX_W-1:0] i);
        calendar_result_t r;
        longint e;
        longint yr;
        longint n;
        longint mon;
        longint dd;
        bit leap;
        r = '0;
        if (!mode) begin
            r.index = date_index(d, m, y);
            return r;
        end
        if (i == 0)
            return r;
        e = longint'(i);
        if (i <= SMALL_INDEX_LIMIT)
            e += longint'(small_index_offset);
        // estimate the year, then step back until its last day lies below e
        yr = e / 365;
        n = last_day_index(yr);
        while (n >= e) begin
            yr -= 1 + (n - e) / 366;
            if (yr < 0)
                yr = 0;
            n = last_day_index(yr);
        end
        yr++;
        n = e - n;
        r.yday = YDAY_W'(n);
        r.wday = WDAY_W'((e + longint'(weekday_shift)) % 7);
        leap = leap_year(yr);
        if (n <= 59 || (leap && n == 60)) begin
            mon = 1 + (n - 1) / 31;
            dd = n + 31 - 31 * mon;
        end else begin
            if (leap)
                n--;
            mon = (10 * n + 323) / 306;
            dd = (10 * n + 333 - 306 * mon) / 10;
        end
        r.year  = YEAR_W'(yr);
        r.month = MON_W'(mon);
        r.day   = DAY_W'(dd);
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] data);
        calendar_result_t want;
        if (pending_conversions.size() == 0) begin
            $display("%0t: result with no conversion pending, expected none, actual %h",
                     $time, data);
            error_count++;
            return;
        end
        want = pending_conversions.pop_front();
        check_field("index_out", want.index, data[21:0]);
        check_field("year_out",  want.year,  data[35:22]);
        check_field("month_out", want.month, data[39:36]);
        check_field("day_out",   want.day,   data[44:40]);
        check_field("yday_out",  want.yday,  data[53:45]);
        check_field("wday_out",  want.wday,  data[56:54]);
    endtask

    // Result side: check each transfer, then pick tready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_result(m_tdata);
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_conversion(input bit mode, input logic [DAY_W-1:0] d,
                                   input logic [MON_W-1:0] m, input logic [YEAR_W-1:0] y,
                                   input logic [IDX_W-1:0] i);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b0, i, y, m, d};
        do @(posedge aclk); while (!s_tready);
        pending_conversions.push_back(predict_conversion(mode, d, m, y, i));
    endtask

    task automatic send_date(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                             input logic [YEAR_W-1:0] y);
        send_conversion(1'b0, d, m, y, IDX_W'($urandom));
    endtask

    task automatic send_index(input logic [IDX_W-1:0] i);
        send_conversion(1'b1, DAY_W'($urandom), MON_W'($urandom), YEAR_W'($urandom), i);
    endtask

    task automatic send_random_conversion();
        logic [DAY_W-1:0]  d;
        logic [MON_W-1:0]  m;
        logic [YEAR_W-1:0] y;
        logic [IDX_W-1:0]  i;
        d = ($urandom_range(9) == 0) ? DAY_W'($urandom_range(31)) : DAY_W'($urandom_range(31, 1));
        m = ($urandom_range(9) == 0) ? MON_W'($urandom_range(15)) : MON_W'($urandom_range(12, 1));
        case ($urandom_range(3))
            0:       y = YEAR_W'($urandom_range(99));
            1:       y = YEAR_W'($urandom_range(2100, 1600));
            default: y = YEAR_W'($urandom_range(9999));
        endcase
        case ($urandom_range(3))
            0:       i = IDX_W'($urandom_range(65535));
            1:       i = IDX_W'($urandom_range(800000, 600000));
            default: i = IDX_W'($urandom);
        endcase
        send_conversion(1'($urandom_range(1)), d, m, y, i);
    endtask

    // Drop tvalid and hold until every pending result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_conversions.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_CENTURY_LIMIT: year_window_limit  = value[CLIM_W-1:0];
            CFG_OFFSET_1900:   small_index_offset = value[IDX_W-1:0];
            CFG_WEEKDAY_BIAS:  weekday_shift      = value[BIAS_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_random_config();
        write_register(CFG_CENTURY_LIMIT, CFG_DATA_W'($urandom_range(100)));
        write_register(CFG_OFFSET_1900, CFG_DATA_W'($urandom));
        write_register(CFG_WEEKDAY_BIAS, CFG_DATA_W'($urandom_range(6)));
    endtask

    task automatic test_directed_dates();
        src_idle_pct  = 20;
        sink_idle_pct = 81;
        send_date(5'd1, 4'd1, 14'd0);       // windowed into 2000
        send_date(5'd31, 4'd12, 14'd49);
        send_date(5'd1, 4'd1, 14'd50);      // windowed into 1950
        send_date(5'd31, 4'd12, 14'd99);
        send_date(5'd1, 4'd1, 14'd100);
        send_date(5'd29, 4'd2, 14'd1752);
        send_date(5'd1, 4'd3, 14'd1700);    // Julian leap year
        send_date(5'd1, 4'd3, 14'd1800);
        send_date(5'd1, 4'd3, 14'd2000);
        send_date(5'd31, 4'd12, 14'd1752);
        send_date(5'd1, 4'd1, 14'd1753);
        send_date(5'd0, 4'd0, 14'd2024);    // month zero goes back a month
        send_date(5'd31, 4'd15, 14'd9999);
        send_date(5'd15, 4'd13, 14'd2023);
        wait_drained();
    endtask

    task automatic test_directed_indices();
        src_idle_pct  = 20;
        sink_idle_pct = 81;
        send_index(22'd0);
        send_index(22'd1);
        send_index(22'd59);
        send_index(22'd60);
        send_index(22'h00FFFF);
        send_index(22'h010000);
        send_index(22'h3FFFFF);
        send_index(date_index(5'd29, 4'd2, 14'd2000));
        send_index(date_index(5'd1, 4'd3, 14'd2000));
        send_index(date_index(5'd31, 4'd12, 14'd1752));
        send_index(date_index(5'd1, 4'd1, 14'd1753));
        send_index(date_index(5'd31, 4'd12, 14'd1700));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count) send_random_conversion();
        wait_drained();
    endtask

    task automatic test_config_extremes();
        write_register(CFG_CENTURY_LIMIT, CFG_DATA_W'(0));
        write_register(CFG_OFFSET_1900, CFG_DATA_W'(0));
        write_register(CFG_WEEKDAY_BIAS, CFG_DATA_W'(0));
        send_index(22'd1);
        test_random_traffic(100, 20, 81);
        write_register(CFG_CENTURY_LIMIT, CFG_DATA_W'(100));
        write_register(CFG_OFFSET_1900, CFG_DATA_W'(22'h3FFFFF));
        write_register(CFG_WEEKDAY_BIAS, CFG_DATA_W'(6));
        send_index(22'h00FFFF);
        test_random_traffic(100, 20, 81);
    endtask

    // Stall the result side long enough to back up the pipeline
    task automatic test_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_left = 200;
        repeat (60) send_random_conversion();
        wait_drained();
        repeat (20) send_random_conversion();
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_dates();
        test_directed_indices();
        test_random_traffic(350, 20, 81);
        test_config_extremes();
        load_random_config();
        test_random_traffic(150, 81, 20);
        load_random_config();
        test_random_traffic(350, 0, 0);
        test_backpressure();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
